// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ghue_pkg.sv -----
// ---------------------------------------------------------------------------
// ghue_pkg
// Constants and types shared by the golden-ratio hue colour pipeline.
// ---------------------------------------------------------------------------
package ghue_pkg;

    // Index and hue widths
    localparam int INDEX_BITS = 16;
    localparam int HUE_BITS   = 32;
    localparam logic [HUE_BITS-1:0] GOLDEN_Q32 = 32'h9E37_79B9;

    // Fixed-point formats
    localparam int LEVEL_BITS = 17;                 // Q1.16
    localparam int FRAC_BITS  = 16;                 // Q0.16 sector fraction
    localparam int SECT_BITS  = 3;
    localparam int TERM_BITS  = 33;                 // Q1.32, up to 1.0
    localparam int CHAN_BITS  = LEVEL_BITS + TERM_BITS - 1;  // Q.48, up to 2^48
    localparam int BYTE_BITS  = 8;
    localparam logic [LEVEL_BITS-1:0] UNIT_Q16 = 17'h1_0000;
    localparam logic [TERM_BITS-1:0]  ONE_Q32  = 33'h1_0000_0000;

    // Pipeline depth
    localparam int NUM_STAGES = 6;

    // APB register map
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_SATURATION = 1'b0;
    localparam logic REG_BRIGHTNESS = 1'b1;

    // Limited saturation and brightness, both at most 1.0
    typedef struct packed {
        logic [LEVEL_BITS-1:0] sat;
        logic [LEVEL_BITS-1:0] val;
    } levels_t;

    // Per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // Sector and the three reduced factors (1 - S), (1 - S*F), (1 - S*(1-F))
    typedef struct packed {
        logic [SECT_BITS-1:0] sector;
        logic [TERM_BITS-1:0] p_term;
        logic [TERM_BITS-1:0] q_term;
        logic [TERM_BITS-1:0] t_term;
    } terms_t;

endpackage

// ----- hw/rtl/ghue_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// ghue_cfg_regs
// APB register file for saturation and brightness, limited to 1.0.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ghue_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ghue_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [ghue_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [ghue_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    output ghue_pkg::levels_t                     levels
);

    logic [ghue_pkg::LEVEL_BITS-1:0] sat_reg;
    logic [ghue_pkg::LEVEL_BITS-1:0] sat_next;
    logic [ghue_pkg::LEVEL_BITS-1:0] bri_reg;
    logic [ghue_pkg::LEVEL_BITS-1:0] bri_next;
    logic                            wr_en;
    logic                            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Write decode
    always_comb
    begin
        sat_next = sat_reg;
        bri_next = bri_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                ghue_pkg::REG_SATURATION: sat_next = pwdata[ghue_pkg::LEVEL_BITS-1:0];
                ghue_pkg::REG_BRIGHTNESS: bri_next = pwdata[ghue_pkg::LEVEL_BITS-1:0];
                default:                  sat_next = sat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 17'h0_8000;
            bri_reg <= ghue_pkg::UNIT_Q16;
        end
        else
        begin
            sat_reg <= sat_next;
            bri_reg <= bri_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            ghue_pkg::REG_SATURATION:
                prdata = ghue_pkg::APB_DATA_BITS'(sat_reg);
            ghue_pkg::REG_BRIGHTNESS:
                prdata = ghue_pkg::APB_DATA_BITS'(bri_reg);
            default:
                prdata = '0;
        endcase
    end

    // Values above one act as one
    assign levels.sat = (sat_reg > ghue_pkg::UNIT_Q16) ? ghue_pkg::UNIT_Q16 : sat_reg;
    assign levels.val = (bri_reg > ghue_pkg::UNIT_Q16) ? ghue_pkg::UNIT_Q16 : bri_reg;

    `ASSERT_NEXT(a_sat_write, wr_en && (reg_sel == ghue_pkg::REG_SATURATION), sat_reg == $past(pwdata[ghue_pkg::LEVEL_BITS-1:0]), "saturation write lost")
    `ASSERT_IMPLY(a_levels_limited, 1'b1, (levels.sat <= ghue_pkg::UNIT_Q16) && (levels.val <= ghue_pkg::UNIT_Q16), "level above one")

endmodule

// ----- hw/rtl/ghue_pipe_ctrl.sv -----
// ---------------------------------------------------------------------------
// ghue_pipe_ctrl
// Valid bits and per-stage load strobes for the colour pipeline.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ghue_pipe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ghue_pkg::pipe_ctrl_t   ctrl
);

    logic [ghue_pkg::NUM_STAGES-1:0] valid_reg;
    logic [ghue_pkg::NUM_STAGES-1:0] valid_next;
    logic [ghue_pkg::NUM_STAGES-1:0] ready;
    logic [ghue_pkg::NUM_STAGES-1:0] prev_valid;

    // A stage takes new data when empty or when its contents move on
    assign ready[ghue_pkg::NUM_STAGES-1] = !valid_reg[ghue_pkg::NUM_STAGES-1] || !out_stall;
    for (genvar k = 0; k < ghue_pkg::NUM_STAGES - 1; k++)
    begin : g_ready
        assign ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign prev_valid = {valid_reg[ghue_pkg::NUM_STAGES-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < ghue_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? prev_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign ctrl.load = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[ghue_pkg::NUM_STAGES-1];

    `ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_reg[0], "accepted request not in stage one")
    `ASSERT_IMPLY(a_no_spurious_stall, !out_stall, !in_stall, "input stalled with free output")

endmodule

// ----- hw/rtl/ghue_front.sv -----
// ---------------------------------------------------------------------------
// ghue_front
// Stages 1-3: golden-ratio hue, sector split, saturation products.
// ---------------------------------------------------------------------------
module ghue_front (
    input  logic                                   clk,
    input  ghue_pkg::pipe_ctrl_t                   ctrl,
    input  logic signed [ghue_pkg::INDEX_BITS-1:0] hue_index,
    input  ghue_pkg::levels_t                      levels,
    output ghue_pkg::terms_t                       terms
);

    localparam int H6_BITS = ghue_pkg::HUE_BITS + 3;

    logic [ghue_pkg::HUE_BITS-1:0]   idx_ext;
    logic [ghue_pkg::HUE_BITS-1:0]   hue_reg;
    logic [ghue_pkg::HUE_BITS-1:0]   hue_next;
    logic [H6_BITS-1:0]              h6;
    logic [ghue_pkg::SECT_BITS-1:0]  sect_reg;
    logic [ghue_pkg::FRAC_BITS-1:0]  frac_reg;
    logic [ghue_pkg::LEVEL_BITS-1:0] frac_inv;
    logic [ghue_pkg::TERM_BITS-1:0]  s_f;
    logic [ghue_pkg::TERM_BITS-1:0]  s_finv;
    logic [ghue_pkg::TERM_BITS-1:0]  s_one;
    ghue_pkg::terms_t                terms_reg;
    ghue_pkg::terms_t                terms_next;

    // Stage 1: hue = low word of index times golden fraction
    assign idx_ext  = ghue_pkg::HUE_BITS'(hue_index);
    assign hue_next = idx_ext * ghue_pkg::GOLDEN_Q32;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
            hue_reg <= hue_next;
    end

    // Stage 2: hue * 6, integer part is the sector
    assign h6 = {1'b0, hue_reg, 2'b00} + {2'b00, hue_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            sect_reg <= h6[H6_BITS-1:ghue_pkg::HUE_BITS];
            frac_reg <= h6[ghue_pkg::HUE_BITS-1:ghue_pkg::HUE_BITS-ghue_pkg::FRAC_BITS];
        end
    end

    // Stage 3: saturation products and the reduced factors
    assign frac_inv = ghue_pkg::UNIT_Q16 - {1'b0, frac_reg};
    assign s_f      = ghue_pkg::TERM_BITS'(levels.sat) * ghue_pkg::TERM_BITS'(frac_reg);
    assign s_finv   = ghue_pkg::TERM_BITS'(levels.sat) * ghue_pkg::TERM_BITS'(frac_inv);
    assign s_one    = {levels.sat, 16'h0000};

    always_comb
    begin
        terms_next.sector = sect_reg;
        terms_next.p_term = ghue_pkg::ONE_Q32 - s_one;
        terms_next.q_term = ghue_pkg::ONE_Q32 - s_f;
        terms_next.t_term = ghue_pkg::ONE_Q32 - s_finv;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
            terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

// ----- hw/rtl/ghue_back.sv -----
// ---------------------------------------------------------------------------
// ghue_back
// Stages 4-6: sector routing, brightness multiply, byte rounding.
// ---------------------------------------------------------------------------
module ghue_back (
    input  logic                                 clk,
    input  ghue_pkg::pipe_ctrl_t                 ctrl,
    input  ghue_pkg::terms_t                     terms,
    input  ghue_pkg::levels_t                    levels,
    output logic [ghue_pkg::BYTE_BITS-1:0]       red_byte,
    output logic [ghue_pkg::BYTE_BITS-1:0]       green_byte,
    output logic [ghue_pkg::BYTE_BITS-1:0]       blue_byte
);

    localparam int SUM_BITS = ghue_pkg::CHAN_BITS + 8;

    localparam logic [ghue_pkg::SECT_BITS-1:0] SECT_RED_YEL = 3'd0;
    localparam logic [ghue_pkg::SECT_BITS-1:0] SECT_YEL_GRN = 3'd1;
    localparam logic [ghue_pkg::SECT_BITS-1:0] SECT_GRN_CYN = 3'd2;
    localparam logic [ghue_pkg::SECT_BITS-1:0] SECT_CYN_BLU = 3'd3;
    localparam logic [ghue_pkg::SECT_BITS-1:0] SECT_BLU_MAG = 3'd4;

    logic [2:0][ghue_pkg::TERM_BITS-1:0] sel_next;
    logic [2:0][ghue_pkg::TERM_BITS-1:0] sel_reg;
    logic [2:0][ghue_pkg::CHAN_BITS-1:0] chan_reg;
    logic [2:0][ghue_pkg::BYTE_BITS-1:0] byte_next;
    logic [2:0][ghue_pkg::BYTE_BITS-1:0] byte_reg;

    // Stage 4: route factors to red, green, blue (index 0, 1, 2)
    always_comb
    begin
        unique case (terms.sector)
            SECT_RED_YEL: sel_next = {terms.p_term, terms.t_term, ghue_pkg::ONE_Q32};
            SECT_YEL_GRN: sel_next = {terms.p_term, ghue_pkg::ONE_Q32, terms.q_term};
            SECT_GRN_CYN: sel_next = {terms.t_term, ghue_pkg::ONE_Q32, terms.p_term};
            SECT_CYN_BLU: sel_next = {ghue_pkg::ONE_Q32, terms.q_term, terms.p_term};
            SECT_BLU_MAG: sel_next = {ghue_pkg::ONE_Q32, terms.p_term, terms.t_term};
            default:      sel_next = {terms.q_term, terms.p_term, ghue_pkg::ONE_Q32};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
            sel_reg <= sel_next;
    end

    // Stage 5: channel = V * factor, Q.48
    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            for (int c = 0; c < 3; c++)
            begin
                chan_reg[c] <= ghue_pkg::CHAN_BITS'(levels.val)
                             * ghue_pkg::CHAN_BITS'(sel_reg[c]);
            end
        end
    end

    // Stage 6: byte = (c * 255 + half) >> 48, clamped
    always_comb
    begin
        logic [SUM_BITS-1:0] sum;
        logic [SUM_BITS-ghue_pkg::CHAN_BITS:0] top;
        for (int c = 0; c < 3; c++)
        begin
            sum = {chan_reg[c], 8'h00} - SUM_BITS'(chan_reg[c])
                + (SUM_BITS'(1) << (ghue_pkg::CHAN_BITS - 2));
            top = sum[SUM_BITS-1:ghue_pkg::CHAN_BITS-1];
            byte_next[c] = (top > 9'd255) ? 8'hFF : top[ghue_pkg::BYTE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
            byte_reg <= byte_next;
    end

    assign red_byte   = byte_reg[0];
    assign green_byte = byte_reg[1];
    assign blue_byte  = byte_reg[2];

endmodule

// ----- hw/rtl/golden_hue_hsv_to_rgb.sv -----
// ---------------------------------------------------------------------------
// golden_hue_hsv_to_rgb
// Palette index to RGB bytes via golden-ratio hue and HSV conversion.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     hue_index
//   output    out_valid / out_stall   red_byte, green_byte, blue_byte
//   config    APB psel/penable        saturation_level @0, brightness_level @4
//
// One request per cycle sustained while the output is not stalled; out_valid
// rises once the accepted request has passed six register stages (hue multiply,
// sector split, saturation multiply, routing, brightness multiply, rounding).
// Each stage only holds when the stage after it is full and held, so
// bubbles close up behind a stalled output. Reset clears the valid bits and
// the registers to 0.5 saturation and full brightness; no clearing pass.
// ---------------------------------------------------------------------------
module golden_hue_hsv_to_rgb (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ghue_pkg::INDEX_BITS-1:0] hue_index,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ghue_pkg::BYTE_BITS-1:0]         red_byte,
    output logic [ghue_pkg::BYTE_BITS-1:0]         green_byte,
    output logic [ghue_pkg::BYTE_BITS-1:0]         blue_byte,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ghue_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [ghue_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ghue_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    ghue_pkg::levels_t    levels;
    ghue_pkg::pipe_ctrl_t ctrl;
    ghue_pkg::terms_t     terms;

    // Configuration registers
    ghue_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .levels  (levels)
    );

    // Pipeline control
    ghue_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    // Hue and saturation stages
    ghue_front u_front (
        .clk       (clk),
        .ctrl      (ctrl),
        .hue_index (hue_index),
        .levels    (levels),
        .terms     (terms)
    );

    // Brightness and rounding stages
    ghue_back u_back (
        .clk        (clk),
        .ctrl       (ctrl),
        .terms      (terms),
        .levels     (levels),
        .red_byte   (red_byte),
        .green_byte (green_byte),
        .blue_byte  (blue_byte)
    );

endmodule

// ----- sim/golden_hue_hsv_to_rgb_tb.sv -----
// ----------------------------------------------------------------------------
// golden_hue_hsv_to_rgb_tb
// Self-checking bench for the golden-ratio hue to RGB pipeline. A local
// fixed-point model predicts the three colour bytes for every accepted
// request. Results are checked in order against that prediction. Stimulus
// covers index extremes, saturation and brightness extremes including values
// above one, random streams under random idling on both sides, and a long
// output hold that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module golden_hue_hsv_to_rgb_tb;

    import ghue_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS  = 57;
    localparam int BURST_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 300;

    // Sector of the hue circle, named by the colours it runs between
    typedef enum logic [SECT_BITS-1:0] {
        SEC_RED_YELLOW     = 3'd0,
        SEC_YELLOW_GREEN   = 3'd1,
        SEC_GREEN_CYAN     = 3'd2,
        SEC_CYAN_BLUE      = 3'd3,
        SEC_BLUE_MAGENTA   = 3'd4,
        SEC_MAGENTA_RED    = 3'd5
    } hue_sector_t;

    typedef struct {
        logic signed [INDEX_BITS-1:0] idx;
        logic [BYTE_BITS-1:0]         red;
        logic [BYTE_BITS-1:0]         green;
        logic [BYTE_BITS-1:0]         blue;
    } rgb_expect_t;

    // DUT signals
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [INDEX_BITS-1:0]  hue_index = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [BYTE_BITS-1:0]          red_byte;
    logic [BYTE_BITS-1:0]          green_byte;
    logic [BYTE_BITS-1:0]          blue_byte;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]      paddr = '0;
    logic [APB_DATA_BITS-1:0]      pwdata = '0;
    logic [APB_DATA_BITS-1:0]      prdata;
    logic                          pready;

    // Local copy of the level registers
    logic [LEVEL_BITS-1:0] sat_reg;
    logic [LEVEL_BITS-1:0] bright_reg;

    rgb_expect_t pending_rgb[$];

    int  errors = 0;
    int  requests_sent = 0;
    int  colours_checked = 0;
    int  level_settings = 0;
    int  input_stall_cycles = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    bit  rx_steady = 1'b0;
    bit  tx_steady = 1'b0;

    golden_hue_hsv_to_rgb uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue_index  (hue_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_byte   (red_byte),
        .green_byte (green_byte),
        .blue_byte  (blue_byte),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("golden_hue_hsv_to_rgb_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Colour prediction
    // ------------------------------------------------------------------

    function automatic logic [63:0] unit_limit(logic [LEVEL_BITS-1:0] level);
        return (level > UNIT_Q16) ? 64'(UNIT_Q16) : 64'(level);
    endfunction

    // Q.48 channel to a byte, round half up, clamp at full scale
    function automatic logic [BYTE_BITS-1:0] chan_byte(logic [63:0] chan);
        logic [63:0] scaled;
        scaled = (chan * 64'd255 + (64'd1 << 47)) >> 48;
        return (scaled > 64'd255) ? 8'hFF : scaled[BYTE_BITS-1:0];
    endfunction

    function automatic rgb_expect_t predict_colour(logic signed [INDEX_BITS-1:0] idx);
        logic [HUE_BITS-1:0] idx_ext;
        logic [HUE_BITS-1:0] hue;
        logic [63:0]         h6;
        logic [63:0]         frac;
        logic [63:0]         s;
        logic [63:0]         v;
        logic [63:0]         cv;
        logic [63:0]         cp;
        logic [63:0]         cq;
        logic [63:0]         ct;
        logic [63:0]         r;
        logic [63:0]         g;
        logic [63:0]         b;
        hue_sector_t         sect;
        rgb_expect_t         res;
        // Negative indices wrap through the two's complement product
        idx_ext = {{(HUE_BITS-INDEX_BITS){idx[INDEX_BITS-1]}}, idx};
        hue     = idx_ext * GOLDEN_Q32;
        h6      = 64'(hue) * 64'd6;
        sect    = hue_sector_t'(h6[HUE_BITS+SECT_BITS-1:HUE_BITS]);
        frac    = 64'(h6[31:16]);
        s       = unit_limit(sat_reg);
        v       = unit_limit(bright_reg);
        cv = v << 32;
        cp = v * ((64'd1 << 32) - s * 64'(UNIT_Q16));
        cq = v * ((64'd1 << 32) - s * frac);
        ct = v * ((64'd1 << 32) - s * (64'(UNIT_Q16) - frac));
        case (sect)
            SEC_RED_YELLOW:   begin r = cv; g = ct; b = cp; end
            SEC_YELLOW_GREEN: begin r = cq; g = cv; b = cp; end
            SEC_GREEN_CYAN:   begin r = cp; g = cv; b = ct; end
            SEC_CYAN_BLUE:    begin r = cp; g = cq; b = cv; end
            SEC_BLUE_MAGENTA: begin r = ct; g = cp; b = cv; end
            default:          begin r = cv; g = cp; b = cq; end
        endcase
        res.idx   = idx;
        res.red   = chan_byte(r);
        res.green = chan_byte(g);
        res.blue  = chan_byte(b);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_byte(string name, logic signed [INDEX_BITS-1:0] idx,
                                       logic [BYTE_BITS-1:0] want,
                                       logic [BYTE_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch for index %0d: expected %0d, got %0d",
                     $time, name, idx, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        rgb_expect_t want;
        if (rst_n && in_valid && in_stall)
            input_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rgb.size() == 0)
            begin
                $display("%0t: unexpected colour: expected none, got r=%0d g=%0d b=%0d",
                         $time, red_byte, green_byte, blue_byte);
                errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                check_byte("red_byte", want.idx, want.red, red_byte);
                check_byte("green_byte", want.idx, want.green, green_byte);
                check_byte("blue_byte", want.idx, want.blue, blue_byte);
                colours_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, or a long hold when asked
    // ------------------------------------------------------------------

    initial
    begin
        int stall_run;
        int pick;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                stall_run = 0;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (rx_steady || pick < 70)
                    out_stall <= 1'b0;
                else if (pick < 95)
                begin
                    out_stall <= 1'b1;
                    stall_run = $urandom_range(0, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_run = $urandom_range(8, 30);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared request and register tasks
    // ------------------------------------------------------------------

    // Offer one index and hold it until taken; in_valid stays high on return
    task automatic send_index(logic signed [INDEX_BITS-1:0] idx);
        in_valid  <= 1'b1;
        hue_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_rgb.push_back(predict_colour(idx));
        requests_sent++;
    endtask

    // Random gap on the input, mostly none, sometimes long
    task automatic input_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (tx_steady || pick < 60)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(5, 20);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop offering, let every result come back and the pipe empty
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    function automatic logic [APB_ADDR_BITS-1:0] level_addr(logic idx);
        return {idx, 2'b00};
    endfunction

    task automatic write_level(logic idx, logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= level_addr(idx);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SATURATION)
            sat_reg = data[LEVEL_BITS-1:0];
        else
            bright_reg = data[LEVEL_BITS-1:0];
        // return the bus to idle before the next transfer
        @(posedge clk);
    endtask

    task automatic read_level(logic idx);
        logic [APB_DATA_BITS-1:0] want;
        want = APB_DATA_BITS'((idx == REG_SATURATION) ? sat_reg : bright_reg);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= level_addr(idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t: readback mismatch at address %0d: expected %0h, got %0h",
                     $time, level_addr(idx), want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // return the bus to idle before the next transfer
        @(posedge clk);
    endtask

    // Write both levels and read them back; only called with the pipe empty
    task automatic set_levels(logic [APB_DATA_BITS-1:0] sat, logic [APB_DATA_BITS-1:0] val);
        write_level(REG_SATURATION, sat);
        write_level(REG_BRIGHTNESS, val);
        read_level(REG_SATURATION);
        read_level(REG_BRIGHTNESS);
        level_settings++;
    endtask

    function automatic logic [APB_DATA_BITS-1:0] random_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 32'(UNIT_Q16);
        else if (pick < 18)
            return 32'd0;
        else if (pick < 28)
            return 32'($urandom_range(65537, 131071));
        else if (pick < 35)
            return $urandom;
        else
            return 32'($urandom_range(0, 65536));
    endfunction

    function automatic logic signed [INDEX_BITS-1:0] random_index();
        int pick;
        pick = $urandom_range(0, 99);
        case (pick % 5)
            0: return (pick < 10) ? 16'sh8000 : INDEX_BITS'($urandom);
            1: return (pick < 10) ? 16'sh7FFF : INDEX_BITS'($urandom);
            2: return (pick < 10) ? 16'sh0000 : INDEX_BITS'($urandom);
            3: return (pick < 10) ? -16'sd1 : INDEX_BITS'($urandom);
            default: return INDEX_BITS'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset levels, then index extremes and both signs
    task automatic test_index_extremes();
        logic signed [INDEX_BITS-1:0] picks[11];
        picks = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, -16'sd2, 16'sh7FFF, 16'sh8000,
                  16'sh5555, 16'shAAAA, 16'sd3, 16'sd5};
        read_level(REG_SATURATION);
        read_level(REG_BRIGHTNESS);
        foreach (picks[i])
            send_index(picks[i]);
        drain_results();
    endtask

    // Grey, full saturation, black, both levels above one, near-zero levels
    task automatic test_level_extremes();
        logic [APB_DATA_BITS-1:0] sats[5];
        logic [APB_DATA_BITS-1:0] vals[5];
        sats = '{32'd0, 32'd65536, 32'd32768, 32'hFFFF_FFFF, 32'd1};
        vals = '{32'd65536, 32'd65536, 32'd0, 32'h0001_8000, 32'd1};
        foreach (sats[i])
        begin
            set_levels(sats[i], vals[i]);
            send_index(16'sd7);
            send_index(-16'sd300);
            drain_results();
        end
    endtask

    // Random indices under random level settings and idling
    task automatic test_random_stream();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase > 0)
                set_levels(random_level(), random_level());
            // some phases run without idling on either side
            rx_steady = (phase == 2) || (phase == 5);
            tx_steady = rx_steady;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                input_gap();
                send_index(random_index());
            end
            drain_results();
        end
        rx_steady = 1'b0;
        tx_steady = 1'b0;
    endtask

    // Long output hold while requests keep coming, a full pause, then a short gapped stream
    task automatic test_backpressure();
        set_levels(32'($urandom_range(0, 65536)), 32'($urandom_range(0, 65536)));
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < BURST_ITEMS; n++)
            send_index(random_index());
        drain_results();
        for (int n = 0; n < 10; n++)
        begin
            input_gap();
            send_index(random_index());
        end
        drain_results();
    endtask

    initial
    begin
        sat_reg    = LEVEL_BITS'(32768);
        bright_reg = UNIT_Q16;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_index_extremes();
        test_level_extremes();
        test_random_stream();
        test_backpressure();

        // All requests are in; wait for the tail of the pipe
        drain_results();
        repeat (2 * NUM_STAGES) @(posedge clk);

        $display("Sent %0d indices, checked %0d colours over %0d level settings",
                 requests_sent, colours_checked, level_settings);
        $display("Input held off on %0d cycles, %0d errors", input_stall_cycles, errors);
        if (errors == 0)
            $display("golden_hue_hsv_to_rgb_tb: PASS");
        else
            $display("golden_hue_hsv_to_rgb_tb: FAIL");
        $finish;
    end

endmodule
